### sv/dng_olp_pkg.sv
// dng_olp_pkg: types, codes and sizes shared by the opcode list parser
// no dependencies
package dng_olp_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  // header and payload layout
  localparam logic [31:0] CountBytes   = 32'd4;
  localparam logic [31:0] HdrIdPos     = 32'd3;
  localparam logic [31:0] HdrFlagsPos  = 32'd11;
  localparam logic [31:0] HdrLastPos   = 32'd15;
  localparam logic [31:0] GainMinLen   = 32'd76;
  localparam logic [31:0] VigMinLen    = 32'd56;
  localparam logic [31:0] WarpMinLen   = 32'd4;
  localparam logic [7:0]  WarpPerPlane = 8'd48;
  localparam logic [7:0]  WarpFixed    = 8'd20;

  localparam logic [31:0] IdWarp = 32'd1;
  localparam logic [31:0] IdVig  = 32'd3;
  localparam logic [31:0] IdGain = 32'd9;

  localparam logic KindOpcode = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [2:0] VerdUnsup    = 3'd0;
  localparam logic [2:0] VerdGainOk   = 3'd1;
  localparam logic [2:0] VerdGainBad  = 3'd2;
  localparam logic [2:0] VerdWarpOk   = 3'd3;
  localparam logic [2:0] VerdWarpBad  = 3'd4;
  localparam logic [2:0] VerdVigOk    = 3'd5;
  localparam logic [2:0] VerdVigSmall = 3'd6;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatCount   = 2'd1;
  localparam logic [1:0] StatHeader  = 2'd2;
  localparam logic [1:0] StatPayload = 2'd3;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_EVAL,
    BK_OUT
  } back_state_e;

  // one event from the front to the back
  typedef struct packed {
    logic        kind;
    logic [31:0] id;
    logic [31:0] flags;
    logic [31:0] len;
    logic [1:0]  status;
    logic [31:0] pv;
    logic [31:0] ph;
    logic [31:0] pl;
    logic        lk;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            room;
  } qstat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] id;
    logic [31:0] flags;
    logic [31:0] len;
    logic [2:0]  verdict;
    logic [1:0]  status;
    logic [31:0] pv;
    logic [31:0] ph;
    logic [31:0] pl;
    logic        last;
  } result_t;

endpackage

### sv/dng_olp_if.sv
// dng_olp_if: byte and result channels of the opcode list parser
// no dependencies
interface dng_olp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, data_byte, final_byte, input ready);
  modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface dng_olp_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [31:0] record_id;
  logic [31:0] opcode_flags;
  logic [31:0] payload_length;
  logic [2:0]  verdict;
  logic [1:0]  list_status;
  logic [31:0] points_vertical;
  logic [31:0] points_horizontal;
  logic [31:0] plane_count;
  logic        run_end;
  modport source (output valid, record_kind, record_id, opcode_flags, payload_length,
                  verdict, list_status, points_vertical, points_horizontal, plane_count,
                  run_end, input ready);
  modport sink (input valid, record_kind, record_id, opcode_flags, payload_length,
                verdict, list_status, points_vertical, points_horizontal, plane_count,
                run_end, output ready);
endinterface

### sv/dng_olp_front.sv
// dng_olp_front: byte parser, emits up to two events per word
// depends on dng_olp_pkg
module dng_olp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,
  input  logic [7:0]              byte_i,
  input  logic                    fin_i,
  input  logic                    lk_i,
  output logic [1:0]              push_n_o,
  output dng_olp_pkg::event_t     ev0_o,
  output dng_olp_pkg::event_t     ev1_o
);

  dng_olp_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d, left_q, left_d, ws_q, ws_d;
  logic [31:0] hid_q, hid_d, hfl_q, hfl_d, hlen_q, hlen_d;
  logic [31:0] cv_q, cv_d, ch_q, ch_d, cp_q, cp_d;
  dng_olp_pkg::event_t ev [2];
  logic [1:0] n;
  logic       fin_op;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    left_d  = left_q;
    ws_d    = ws_q;
    hid_d   = hid_q;
    hfl_d   = hfl_q;
    hlen_d  = hlen_q;
    cv_d    = cv_q;
    ch_d    = ch_q;
    cp_d    = cp_q;
    ev[0]   = '0;
    ev[1]   = '0;
    n       = 2'd0;
    fin_op  = 1'b0;
    if (acc_i) begin
      case (phase_q)
        dng_olp_pkg::PH_COUNT: begin
          ws_d  = {ws_q[23:0], byte_i};
          pos_d = pos_q + 32'd1;
          if (pos_d >= dng_olp_pkg::CountBytes) begin
            left_d = ws_d;
            pos_d  = '0;
            if (ws_d == '0) begin
              ev[0].kind = dng_olp_pkg::KindStatus;
              n          = 2'd1;
              phase_d    = dng_olp_pkg::PH_DONE;
            end else begin
              phase_d = dng_olp_pkg::PH_HEADER;
            end
          end
        end
        dng_olp_pkg::PH_HEADER: begin
          ws_d  = {ws_q[23:0], byte_i};
          pos_d = pos_q + 32'd1;
          if (pos_q == dng_olp_pkg::HdrIdPos) begin
            hid_d = ws_d;
          end else if (pos_q == dng_olp_pkg::HdrFlagsPos) begin
            hfl_d = ws_d;
          end else if (pos_q >= dng_olp_pkg::HdrLastPos) begin
            hlen_d = ws_d;
            cv_d   = '0;
            ch_d   = '0;
            cp_d   = '0;
            pos_d  = '0;
            if (ws_d == '0) begin
              fin_op = 1'b1;
            end else begin
              phase_d = dng_olp_pkg::PH_PAYLOAD;
            end
          end
        end
        dng_olp_pkg::PH_PAYLOAD: begin
          pos_d = pos_q + 32'd1;
          if (!lk_i) begin
            if (pos_q >= 32'd32 && pos_q < 32'd36) begin
              cv_d = {cv_q[23:0], byte_i};
            end else if (pos_q >= 32'd36 && pos_q < 32'd40) begin
              ch_d = {ch_q[23:0], byte_i};
            end else if (pos_q >= 32'd72 && pos_q < 32'd76) begin
              cp_d = {cp_q[23:0], byte_i};
            end
          end else if (pos_q < 32'd4) begin
            cp_d = {cp_q[23:0], byte_i};
          end
          if (pos_d >= hlen_q) begin
            fin_op = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // opcode complete: record, then list status on the last opcode
      if (fin_op) begin
        ev[0].kind  = dng_olp_pkg::KindOpcode;
        ev[0].id    = hid_d;
        ev[0].flags = hfl_d;
        ev[0].len   = hlen_d;
        ev[0].pv    = cv_d;
        ev[0].ph    = ch_d;
        ev[0].pl    = cp_d;
        ev[0].lk    = lk_i;
        n           = 2'd1;
        left_d      = left_q - 32'd1;
        pos_d       = '0;
        if (left_d == '0) begin
          ev[1].kind = dng_olp_pkg::KindStatus;
          n          = 2'd2;
          phase_d    = dng_olp_pkg::PH_DONE;
        end else begin
          phase_d = dng_olp_pkg::PH_HEADER;
        end
      end

      // final byte: truncation status if unfinished, then clear
      if (fin_i) begin
        if (phase_d != dng_olp_pkg::PH_DONE) begin
          ev[n[0]].kind = dng_olp_pkg::KindStatus;
          case (phase_d)
            dng_olp_pkg::PH_COUNT:   ev[n[0]].status = dng_olp_pkg::StatCount;
            dng_olp_pkg::PH_HEADER:  ev[n[0]].status = dng_olp_pkg::StatHeader;
            default:                 ev[n[0]].status = dng_olp_pkg::StatPayload;
          endcase
          n = n + 2'd1;
        end
        phase_d = dng_olp_pkg::PH_COUNT;
        pos_d   = '0;
        left_d  = '0;
        ws_d    = '0;
        hid_d   = '0;
        hfl_d   = '0;
        hlen_d  = '0;
        cv_d    = '0;
        ch_d    = '0;
        cp_d    = '0;
      end
      if (n == 2'd1) ev[0].last = 1'b1;
      if (n == 2'd2) ev[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dng_olp_pkg::PH_COUNT;
      pos_q   <= '0;
      left_q  <= '0;
      ws_q    <= '0;
      hid_q   <= '0;
      hfl_q   <= '0;
      hlen_q  <= '0;
      cv_q    <= '0;
      ch_q    <= '0;
      cp_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      ws_q    <= ws_d;
      hid_q   <= hid_d;
      hfl_q   <= hfl_d;
      hlen_q  <= hlen_d;
      cv_q    <= cv_d;
      ch_q    <= ch_d;
      cp_q    <= cp_d;
    end
  end

  assign push_n_o = n;
  assign ev0_o    = ev[0];
  assign ev1_o    = ev[1];

endmodule

### sv/dng_olp_queue.sv
// dng_olp_queue: short event queue, two writes and one read per cycle
// depends on dng_olp_pkg
module dng_olp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  dng_olp_pkg::event_t ev0_i,
  input  dng_olp_pkg::event_t ev1_i,
  input  logic                pop_i,
  output logic                valid_o,
  output dng_olp_pkg::event_t head_o,
  output dng_olp_pkg::qstat_t stat_o
);

  dng_olp_pkg::event_t mem_q [dng_olp_pkg::QDepth];
  logic [dng_olp_pkg::PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [dng_olp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [dng_olp_pkg::PtrW-1:0] wp1;

  assign wp1 = wp_q + dng_olp_pkg::PtrW'(1);

  always_comb begin
    wp_d  = wp_q + dng_olp_pkg::PtrW'(push_n_i);
    rp_d  = rp_q + dng_olp_pkg::PtrW'(pop_i);
    cnt_d = cnt_q + dng_olp_pkg::CntW'(push_n_i) - dng_olp_pkg::CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wp_q] <= ev0_i;
    if (push_n_i == 2'd2) mem_q[wp1]  <= ev1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o      = cnt_q != '0;
  assign head_o       = mem_q[rp_q];
  assign stat_o.count = cnt_q;
  // room for the two events one word can cause
  assign stat_o.room  = cnt_q <= dng_olp_pkg::CntW'(dng_olp_pkg::QDepth - 2);

endmodule

### sv/dng_olp_back.sv
// dng_olp_back: size checks and verdict, holds the result register
// depends on dng_olp_pkg
module dng_olp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  dng_olp_pkg::event_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dng_olp_pkg::result_t res_o
);

  dng_olp_pkg::back_state_e st_q, st_d;
  dng_olp_pkg::event_t  cur_q;
  dng_olp_pkg::result_t res_q, res_d;
  logic [63:0] vh_q, prod_q;
  logic [31:0] gains, need;
  logic        fits;

  always_comb begin
    st_d  = st_q;
    pop_o = 1'b0;
    case (st_q)
      dng_olp_pkg::BK_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          st_d  = dng_olp_pkg::BK_MUL1;
        end
      end
      dng_olp_pkg::BK_MUL1: st_d = dng_olp_pkg::BK_MUL2;
      dng_olp_pkg::BK_MUL2: st_d = dng_olp_pkg::BK_EVAL;
      dng_olp_pkg::BK_EVAL: st_d = dng_olp_pkg::BK_OUT;
      dng_olp_pkg::BK_OUT: begin
        if (out_ready_i) st_d = dng_olp_pkg::BK_IDLE;
      end
      default: st_d = dng_olp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= dng_olp_pkg::BK_IDLE;
    else         st_q <= st_d;
  end

  // verdict logic
  always_comb begin
    gains = {2'b00, 30'((cur_q.len - dng_olp_pkg::GainMinLen) >> 2)};
    if (vh_q == '0 || cur_q.pl == '0) fits = 1'b1;
    else if (vh_q > {32'd0, gains})  fits = 1'b0;
    else                              fits = prod_q <= {32'd0, gains};
    need  = {24'd0, dng_olp_pkg::WarpPerPlane * {6'd0, cur_q.pl[1:0]}
                    + dng_olp_pkg::WarpFixed};
    res_d        = '0;
    res_d.kind   = cur_q.kind;
    res_d.status = cur_q.status;
    res_d.last   = cur_q.last;
    if (cur_q.kind == dng_olp_pkg::KindOpcode) begin
      res_d.id    = cur_q.id;
      res_d.flags = cur_q.flags;
      res_d.len   = cur_q.len;
      if (!cur_q.lk) begin
        if (cur_q.id == dng_olp_pkg::IdGain) begin
          if (cur_q.len < dng_olp_pkg::GainMinLen) begin
            res_d.verdict = dng_olp_pkg::VerdGainBad;
          end else begin
            res_d.verdict = fits ? dng_olp_pkg::VerdGainOk : dng_olp_pkg::VerdGainBad;
            res_d.pv      = cur_q.pv;
            res_d.ph      = cur_q.ph;
            res_d.pl      = cur_q.pl;
          end
        end
      end else if (cur_q.id == dng_olp_pkg::IdWarp) begin
        if (cur_q.len < dng_olp_pkg::WarpMinLen) begin
          res_d.verdict = dng_olp_pkg::VerdWarpBad;
        end else begin
          res_d.pl = cur_q.pl;
          if (cur_q.pl == '0 || cur_q.pl > 32'd3 || cur_q.len < need)
            res_d.verdict = dng_olp_pkg::VerdWarpBad;
          else
            res_d.verdict = dng_olp_pkg::VerdWarpOk;
        end
      end else if (cur_q.id == dng_olp_pkg::IdVig) begin
        res_d.verdict = (cur_q.len < dng_olp_pkg::VigMinLen) ?
                        dng_olp_pkg::VerdVigSmall : dng_olp_pkg::VerdVigOk;
      end
    end
  end

  // vh fits 30 bits whenever the second product matters
  always_ff @(posedge clk_i) begin
    if (pop_o)                        cur_q  <= head_i;
    if (st_q == dng_olp_pkg::BK_MUL1) vh_q   <= cur_q.pv * cur_q.ph;
    if (st_q == dng_olp_pkg::BK_MUL2) prod_q <= {34'd0, vh_q[29:0]} * {32'd0, cur_q.pl};
    if (st_q == dng_olp_pkg::BK_EVAL) res_q  <= res_d;
  end

  assign out_valid_o = st_q == dng_olp_pkg::BK_OUT;
  assign res_o       = res_q;

endmodule

### sv/dng_opcode_list_parser.sv
// dng_opcode_list_parser: opcode list checker top level
// depends on dng_olp_pkg, dng_olp_if, dng_olp_front, dng_olp_queue, dng_olp_back
//
// channel   dir   carries
// in_i      sink  data_byte, final_byte: one buffer byte per word
// out_o     src   opcode record or end-of-list status per word
// cfg       in    cfg_we_i / cfg_wdata_i: list_kind
//
// the front takes one byte a cycle whenever the event queue has room for two
// each result passes through the back in order: pop, two multiplier stages
// (points product, then times planes), verdict, and the output register
// a long payload streams one byte a cycle while there is room, with no back work
// the queue holds four events; a stalled output backs up into in_i.ready
// reset clears parse state, queue pointers and list_kind
module dng_opcode_list_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  dng_olp_in_if.sink           in_i,
  dng_olp_out_if.source        out_o
);

  logic                 list_kind_q;
  logic                 acc;
  logic [1:0]           push_n;
  dng_olp_pkg::event_t  ev0, ev1, head;
  dng_olp_pkg::qstat_t  qstat;
  logic                 q_valid, pop;
  dng_olp_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       list_kind_q <= 1'b0;
    else if (cfg_we_i) list_kind_q <= cfg_wdata_i;
  end

  // a word is taken only with room for both events it may cause
  assign in_i.ready = qstat.room;
  assign acc        = in_i.valid && qstat.room;

  dng_olp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .byte_i   (in_i.data_byte),
    .fin_i    (in_i.final_byte),
    .lk_i     (list_kind_q),
    .push_n_o (push_n),
    .ev0_o    (ev0),
    .ev1_o    (ev1)
  );

  dng_olp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .ev0_i    (ev0),
    .ev1_i    (ev1),
    .pop_i    (pop),
    .valid_o  (q_valid),
    .head_o   (head),
    .stat_o   (qstat)
  );

  dng_olp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.record_kind       = res.kind;
  assign out_o.record_id         = res.id;
  assign out_o.opcode_flags      = res.flags;
  assign out_o.payload_length    = res.len;
  assign out_o.verdict           = res.verdict;
  assign out_o.list_status       = res.status;
  assign out_o.points_vertical   = res.pv;
  assign out_o.points_horizontal = res.ph;
  assign out_o.plane_count       = res.pl;
  assign out_o.run_end           = res.last;

`ifndef SYNTH
  // queue never overfills
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= dng_olp_pkg::CntW'(dng_olp_pkg::QDepth))
    else $error("event queue overflow");
  // a status word carries no verdict
  a_stat_verd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.record_kind == dng_olp_pkg::KindStatus |->
    out_o.verdict == dng_olp_pkg::VerdUnsup)
    else $error("verdict on status word");
  // an opcode record carries ok list status
  a_rec_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.record_kind == dng_olp_pkg::KindOpcode |->
    out_o.list_status == dng_olp_pkg::StatOk)
    else $error("list status on opcode record");
`endif

endmodule

### dv/dng_olp_tb_if.sv
// dng_olp_tb_pkg: expected result word and scoreboard for the opcode list parser
// depends on dng_olp_pkg
package dng_olp_tb_pkg;

  // expected result word as the scoreboard holds it
  typedef struct packed {
    logic        kind;
    logic [31:0] id;
    logic [31:0] flags;
    logic [31:0] len;
    logic [2:0]  verdict;
    logic [1:0]  status;
    logic [31:0] pv;
    logic [31:0] ph;
    logic [31:0] pl;
    logic        last;
  } rec_t;

  class list_scoreboard;
    logic                kind_sel;
    dng_olp_pkg::phase_e phase;
    logic [31:0]         pos, left, shreg, hid, hflags, hlen, cv, ch, cp;
    rec_t                pending[$];
    rec_t                step_out[$];
    int                  errors;

    function void clear_parse();
      phase = dng_olp_pkg::PH_COUNT; pos = 0; left = 0; shreg = 0;
      hid = 0; hflags = 0; hlen = 0; cv = 0; ch = 0; cp = 0;
    endfunction

    function new();
      kind_sel = 0; errors = 0;
      clear_parse();
    endfunction

    function void emit(logic k, logic [31:0] id, logic [31:0] fl, logic [31:0] ln,
                       logic [2:0] v, logic [1:0] st, logic [31:0] a, logic [31:0] b,
                       logic [31:0] c);
      rec_t r;
      r.kind = k; r.id = id; r.flags = fl; r.len = ln; r.verdict = v; r.status = st;
      r.pv = a; r.ph = b; r.pl = c; r.last = 0;
      if (step_out.size() < 2) step_out.push_back(r);
    endfunction

    function void emit_status(logic [1:0] st);
      emit(dng_olp_pkg::KindStatus, 0, 0, 0, dng_olp_pkg::VerdUnsup, st, 0, 0, 0);
    endfunction

    function void close_opcode();
      logic [2:0]   v;
      logic [31:0]  a, b, c;
      logic [127:0] prod, gains;
      v = dng_olp_pkg::VerdUnsup; a = 0; b = 0; c = 0;
      if (!kind_sel) begin
        if (hid == dng_olp_pkg::IdGain) begin
          if (hlen < dng_olp_pkg::GainMinLen) v = dng_olp_pkg::VerdGainBad;
          else begin
            gains = (hlen - dng_olp_pkg::GainMinLen) / 4;
            prod = 128'(cv) * 128'(ch) * 128'(cp);
            v = (prod <= gains) ? dng_olp_pkg::VerdGainOk : dng_olp_pkg::VerdGainBad;
            a = cv; b = ch; c = cp;
          end
        end
      end else if (hid == dng_olp_pkg::IdWarp) begin
        if (hlen < dng_olp_pkg::WarpMinLen) v = dng_olp_pkg::VerdWarpBad;
        else begin
          c = cp;
          if (cp < 1 || cp > 3 || 64'(hlen) < 64'd20 + 64'd48 * 64'(cp))
            v = dng_olp_pkg::VerdWarpBad;
          else v = dng_olp_pkg::VerdWarpOk;
        end
      end else if (hid == dng_olp_pkg::IdVig) begin
        v = (hlen < dng_olp_pkg::VigMinLen) ? dng_olp_pkg::VerdVigSmall
                                             : dng_olp_pkg::VerdVigOk;
      end
      emit(dng_olp_pkg::KindOpcode, hid, hflags, hlen, v, dng_olp_pkg::StatOk, a, b, c);
      left = left - 1; pos = 0;
      if (left == 0) begin
        emit_status(dng_olp_pkg::StatOk);
        phase = dng_olp_pkg::PH_DONE;
      end else begin
        phase = dng_olp_pkg::PH_HEADER;
      end
    endfunction

    // note one accepted byte and queue what it should produce
    function void note_byte(logic [7:0] d, logic fin);
      logic [31:0] idx;
      step_out.delete();
      case (phase)
        dng_olp_pkg::PH_COUNT: begin
          shreg = {shreg[23:0], d}; pos++;
          if (pos >= dng_olp_pkg::CountBytes) begin
            left = shreg; pos = 0;
            if (left == 0) begin
              emit_status(dng_olp_pkg::StatOk);
              phase = dng_olp_pkg::PH_DONE;
            end else begin
              phase = dng_olp_pkg::PH_HEADER;
            end
          end
        end
        dng_olp_pkg::PH_HEADER: begin
          shreg = {shreg[23:0], d}; idx = pos; pos++;
          if (idx == dng_olp_pkg::HdrIdPos) hid = shreg;
          else if (idx == dng_olp_pkg::HdrFlagsPos) hflags = shreg;
          else if (idx >= dng_olp_pkg::HdrLastPos) begin
            hlen = shreg; cv = 0; ch = 0; cp = 0; pos = 0;
            if (hlen == 0) close_opcode();
            else phase = dng_olp_pkg::PH_PAYLOAD;
          end
        end
        dng_olp_pkg::PH_PAYLOAD: begin
          idx = pos; pos++;
          if (!kind_sel) begin
            if (idx >= 32 && idx < 36) cv = {cv[23:0], d};
            else if (idx >= 36 && idx < 40) ch = {ch[23:0], d};
            else if (idx >= 72 && idx < 76) cp = {cp[23:0], d};
          end else if (idx < 4) cp = {cp[23:0], d};
          if (pos >= hlen) close_opcode();
        end
        default: ;
      endcase
      if (fin) begin
        if (phase == dng_olp_pkg::PH_COUNT) emit_status(dng_olp_pkg::StatCount);
        else if (phase == dng_olp_pkg::PH_HEADER) emit_status(dng_olp_pkg::StatHeader);
        else if (phase == dng_olp_pkg::PH_PAYLOAD) emit_status(dng_olp_pkg::StatPayload);
        clear_parse();
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
      foreach (step_out[i]) pending.push_back(step_out[i]);
    endfunction

    function void check_word(rec_t got, time t);
      rec_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%h", t, got.kind, got.id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        $display("%0t: mismatch expected kind=%0d id=%h fl=%h len=%h v=%0d st=%0d",
                 t, e.kind, e.id, e.flags, e.len, e.verdict, e.status,
                 " pv=%h ph=%h pl=%h last=%0d", e.pv, e.ph, e.pl, e.last);
        $display("%0t: mismatch actual   kind=%0d id=%h fl=%h len=%h v=%0d st=%0d",
                 t, got.kind, got.id, got.flags, got.len, got.verdict, got.status,
                 " pv=%h ph=%h pl=%h last=%0d", got.pv, got.ph, got.pl, got.last);
      end
    endfunction
  endclass
endpackage

### dv/dng_opcode_list_parser_tb.sv
// dng_opcode_list_parser_tb: streams opcode lists into the parser and checks each word
// depends on dng_olp_pkg, dng_olp_if, dng_olp_tb_pkg and the parser rtl
module dng_opcode_list_parser_tb;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic cfg_wdata_i = 0;
  int   src_idle = 0, snk_idle = 0;   // percent
  int   hold_off = 0;                 // cycles the receiver still waits
  int   cycles = 0;
  dng_olp_tb_pkg::list_scoreboard sb;
  logic [7:0] bytes[$];
  logic       fins[$];

  dng_olp_in_if  in_ch();
  dng_olp_out_if out_ch();

  dng_opcode_list_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // sample accepted result words
  always @(posedge clk_i) begin
    dng_olp_tb_pkg::rec_t r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      r.kind = out_ch.record_kind; r.id = out_ch.record_id; r.flags = out_ch.opcode_flags;
      r.len = out_ch.payload_length; r.verdict = out_ch.verdict;
      r.status = out_ch.list_status; r.pv = out_ch.points_vertical;
      r.ph = out_ch.points_horizontal; r.pl = out_ch.plane_count; r.last = out_ch.run_end;
      sb.check_word(r, $time);
    end
  end

  // push one word and wait for its handshake
  task automatic send_byte(logic [7:0] d, logic fin);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1; in_ch.data_byte <= d; in_ch.final_byte <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_byte(d, fin);
    @(negedge clk_i);
  endtask

  task automatic flush_queue();
    in_ch.valid <= 0;
    @(negedge clk_i);
    while (sb.pending.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_kind(logic k);
    flush_queue();
    cfg_we_i <= 1; cfg_wdata_i <= k;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.kind_sel = k;
  endtask

  task automatic put32(logic [31:0] w);
    for (int i = 3; i >= 0; i--) bytes.push_back(w[i*8 +: 8]);
  endtask

  // build one opcode with a payload shaped for the current kind
  task automatic add_opcode(logic [31:0] id, logic [31:0] len, bit wide);
    logic [31:0] a, b, c;
    put32(id); put32($urandom); put32($urandom); put32(len);
    a = wide ? $urandom : $urandom_range(4);
    b = wide ? $urandom : $urandom_range(4);
    c = wide ? $urandom : $urandom_range(4);
    for (int i = 0; i < len; i++) begin
      if (i >= 32 && i < 36) bytes.push_back(a[(35-i)*8 +: 8]);
      else if (i >= 36 && i < 40) bytes.push_back(b[(39-i)*8 +: 8]);
      else if (i >= 72 && i < 76) bytes.push_back(c[(75-i)*8 +: 8]);
      else if (i < 4 && sb.kind_sel) bytes.push_back(i == 3 ? c[7:0] : 8'h00);
      else bytes.push_back($urandom);
    end
  endtask

  // stream the queued bytes; final flag on the last, maybe cut short
  task automatic send_list(int cut);
    int n;
    n = bytes.size();
    if (cut >= 0 && cut < n) n = cut + 1;
    for (int i = 0; i < n; i++) send_byte(bytes[i], i == n - 1);
    bytes.delete();
  endtask

  task automatic random_list();
    int nops, len;
    logic [31:0] id;
    nops = $urandom_range(3);
    put32(nops);
    for (int k = 0; k < nops; k++) begin
      case ($urandom_range(5))
        0: id = dng_olp_pkg::IdWarp;
        1: id = dng_olp_pkg::IdVig;
        2, 3: id = dng_olp_pkg::IdGain;
        default: id = $urandom_range(12);
      endcase
      case ($urandom_range(4))
        0: len = 0; 1: len = $urandom_range(10); 2: len = $urandom_range(50, 80);
        default: len = $urandom_range(70, 130);
      endcase
      add_opcode(id, len, $urandom_range(7) == 0);
    end
    if ($urandom_range(9) == 0) begin
      bytes.delete();
      for (int i = $urandom_range(1, 20); i > 0; i--) bytes.push_back($urandom);
    end
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 4)) bytes.push_back($urandom);
    send_list($urandom_range(7) == 0 ? $urandom_range(bytes.size()) : -1);
  endtask

  initial begin
    sb = new();
    in_ch.valid = 0; in_ch.data_byte = 0; in_ch.final_byte = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: zero count, extremes, truncations, empty payload
    put32(0); send_list(-1);
    put32(1); add_opcode(dng_olp_pkg::IdGain, 0, 0); send_list(-1);
    put32(2); add_opcode(dng_olp_pkg::IdGain, 76, 1);
    add_opcode(dng_olp_pkg::IdGain, 100, 0); send_list(-1);
    send_byte(8'hFF, 1);
    put32(32'hFFFFFFFF); bytes.push_back(8'h00); send_list(-1);
    put32(1); add_opcode(dng_olp_pkg::IdGain, 90, 0); send_list(40);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, 0);
    send_byte(8'h00, 1);
    write_kind(1);
    put32(3); add_opcode(dng_olp_pkg::IdWarp, 164, 0); add_opcode(dng_olp_pkg::IdWarp, 3, 0);
    add_opcode(dng_olp_pkg::IdVig, 55, 0); send_list(-1);
    put32(1); add_opcode(dng_olp_pkg::IdVig, 56, 0); send_list(-1);
    write_kind(0);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = ph == 0 ? 21 : ph == 1 ? 50 : 0;
      snk_idle = ph == 0 ? 50 : ph == 1 ? 21 : 0;
      for (int n = 0; n < 4; n++) begin
        if (n == 2) write_kind($urandom_range(1));
        if (ph == 1 && n == 1) begin
          // long stall while short lists keep coming, so the queue backs up
          hold_off = 300;
          repeat (6) begin
            put32(0); send_list(-1);
          end
        end
        if (ph == 2 && n == 3) flush_queue();    // sender waits for every result
        random_list();
      end
    end
    flush_queue();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### sim.f
sv/dng_olp_pkg.sv
sv/dng_olp_if.sv
sv/dng_olp_front.sv
sv/dng_olp_queue.sv
sv/dng_olp_back.sv
sv/dng_opcode_list_parser.sv
dv/dng_olp_tb_if.sv
dv/dng_opcode_list_parser_tb.sv
